### hdl/sss_pkg.sv
// Package for the stock span stream block: widths, limits, item and entry types.
// Depends on nothing; every other file of the block imports it.
package sss_pkg;

   localparam int STACK_DEPTH  = 256;
   localparam int SERIES_LIMIT = 65536;

   localparam int PRICE_W = 32;
   localparam int IDX_W   = $clog2(SERIES_LIMIT);
   localparam int SPAN_W  = $clog2(SERIES_LIMIT + 1);
   localparam int COUNT_W = $clog2(SERIES_LIMIT + 1);
   localparam int FILL_W  = $clog2(STACK_DEPTH + 1);

   localparam logic [FILL_W-1:0]  FILL_FULL   = FILL_W'(STACK_DEPTH);
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(SERIES_LIMIT);
   localparam logic [SPAN_W-1:0]  SPAN_LIMIT  = SPAN_W'(SERIES_LIMIT);

   typedef struct packed {
      logic                      series_start;
      logic signed [PRICE_W-1:0] price;
   } req_type;

   typedef struct packed {
      logic [SPAN_W-1:0] span_length;
      logic              stack_overflowed;
   } rsp_type;

   typedef struct packed {
      logic signed [PRICE_W-1:0] price;
      logic [IDX_W-1:0]          index;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } shift_ctrl_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

### hdl/stock_span_stream.sv
// Top level of the stock span stream block: control, fill and item counters, result register.
// Depends on sss_pkg, sss_stack and sss_cell.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------
//   req     | in        | req_valid / req_ready   | series_start, price
//   rsp     | out       | rsp_valid / rsp_ready   | span_length, stack_overflowed
//
// Scan: an item pops top entries while they are priced below it, then finishes;
//   the stack pops one entry per cycle through the shifting cell row, and each
//   entry pops at most once.
// Reset: synchronous, active high; clears state, fill, item count and overflow flag.
//   Cell contents are not reset; only entries below the fill count are ever read.
// Stalls: a new item is taken while the previous result waits in the result
//   register; the item finishes only once that register is free.
module stock_span_stream (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sss_pkg::rsp_type rsp_data
);
   import sss_pkg::*;

   state_type state_ff, state_in;

   req_type            item_ff;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               overflow_ff, overflow_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   shift_ctrl_type ctl;
   entry_type      push_entry, top_entry;

   logic accept, out_free, saturated, pop_hit, finish;
   logic [SPAN_W-1:0] span_w;

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign saturated = count_ff >= COUNT_LIMIT;
   // Pop while the top entry is strictly below the current price.
   assign pop_hit   = (fill_ff != '0) && ($signed(top_entry.price) < $signed(item_ff.price));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (finish) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      req_ready = 1'b0;
      ctl       = '0;
      finish    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SCAN: begin
            if (!saturated && pop_hit) begin
               ctl.pop = 1'b1;
            end else if (out_free) begin
               finish   = 1'b1;
               ctl.push = !saturated;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign push_entry.price = item_ff.price;
   assign push_entry.index = count_ff[IDX_W-1:0];

   // Span: whole series so far when the stack is empty, else distance to the top entry.
   always_comb begin
      if (fill_ff == '0) begin
         span_w = SPAN_W'(count_ff) + SPAN_W'(1);
      end else begin
         span_w = SPAN_W'(count_ff) - SPAN_W'(top_entry.index);
      end
   end

   // Fill, item count and overflow flag
   always_comb begin
      fill_in     = fill_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (accept && req_data.series_start) begin
         fill_in     = '0;
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (ctl.pop) begin
         fill_in = fill_ff - FILL_W'(1);
      end else if (ctl.push) begin
         count_in = count_ff + COUNT_W'(1);
         // Full stack: the bottom cell drops off the row, fill stays put.
         if (fill_ff == FILL_FULL) begin
            overflow_in = 1'b1;
         end else begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (finish) begin
         rsp_valid_in = 1'b1;
         if (saturated) begin
            rsp_in.span_length      = SPAN_LIMIT;
            rsp_in.stack_overflowed = overflow_ff;
         end else begin
            rsp_in.span_length      = span_w;
            rsp_in.stack_overflowed = overflow_ff || (fill_ff == FILL_FULL);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: hold the accepted item and the pending result
   always_ff @(posedge clock) begin
      if (accept) item_ff <= req_data;
      rsp_ff <= rsp_in;
   end

   sss_stack u_stack (
      .clock      (clock),
      .ctl        (ctl),
      .push_entry (push_entry),
      .top_entry  (top_entry)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Fill never passes the cell count
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("stack fill above depth");

   // Push and pop never in the same cycle
   a_no_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(ctl.push && ctl.pop))
      else $error("push and pop together");

   // Pop only from a non-empty stack
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> (fill_ff != '0))
      else $error("pop from empty stack");

   // Pushing onto a full stack sets the sticky overflow flag
   a_overflow_set: assert property (@(posedge clock) disable iff (reset)
      (ctl.push && fill_ff == FILL_FULL) |=> overflow_ff)
      else $error("overflow flag not set");

   // A finished item never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten");

endmodule

### hdl/sss_cell.sv
// One stack cell: holds one (price, index) entry and shifts with its neighbors.
// Depends on sss_pkg.
module sss_cell (
   input  logic                   clock,
   input  sss_pkg::shift_ctrl_type ctl,
   input  sss_pkg::entry_type      upper_entry,
   input  sss_pkg::entry_type      lower_entry,
   output sss_pkg::entry_type      entry
);
   import sss_pkg::*;

   entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.push) begin
         entry_in = upper_entry;
      end else if (ctl.pop) begin
         entry_in = lower_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

### hdl/sss_stack.sv
// Row of stack cells; cell 0 is the top of the stack.
// Depends on sss_pkg and sss_cell.
module sss_stack (
   input  logic                   clock,
   input  sss_pkg::shift_ctrl_type ctl,
   input  sss_pkg::entry_type      push_entry,
   output sss_pkg::entry_type      top_entry
);
   import sss_pkg::*;

   entry_type cell_q [STACK_DEPTH];

   for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
      entry_type upper_w, lower_w;
      if (g == 0) begin : g_top
         assign upper_w = push_entry;
      end else begin : g_mid
         assign upper_w = cell_q[g-1];
      end
      // The bottom cell's pop source is don't-care: hold it.
      if (g == STACK_DEPTH - 1) begin : g_bot
         assign lower_w = cell_q[g];
      end else begin : g_nbot
         assign lower_w = cell_q[g+1];
      end
      sss_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .upper_entry (upper_w),
         .lower_entry (lower_w),
         .entry       (cell_q[g])
      );
   end

   assign top_entry = cell_q[0];

endmodule
